// File: src/pdd_pkg.sv
// Shared types and constants for the polyline delta decoder.
`timescale 1ns / 1ps

package pdd_pkg;

   // Character decoding constants
   localparam logic [7:0] CHAR_BIAS    = 8'd63;
   localparam logic [7:0] CONT_LOW     = 8'd95;
   localparam logic [7:0] CONT_HIGH    = 8'd127;
   localparam logic [2:0] MAX_CHUNKS   = 3'd7;
   localparam logic [15:0] MAX_PTS_RST = 16'hFFFF;

   // Result status codes
   localparam logic [1:0] STAT_BUSY     = 2'd0;
   localparam logic [1:0] STAT_DONE     = 2'd1;
   localparam logic [1:0] STAT_TRUNC    = 2'd2;
   localparam logic [1:0] STAT_OVERLONG = 2'd3;

   // Per-string decoding mode
   typedef enum logic [1:0] {
      MODE_DECODING = 2'd0,
      MODE_LIMIT    = 2'd1,
      MODE_VOID     = 2'd2
   } mode_type;

   // One result beat
   typedef struct packed {
      logic signed [31:0] lat_units;
      logic signed [31:0] lon_units;
      logic               point_valid;
      logic [1:0]         status;
      logic [15:0]        points_so_far;
   } rsp_type;

endpackage

// File: src/polyline_delta_decoder_unit.sv
// Top level: input register, decode core and result buffer.
// A result beat is offered from the result buffer after its character has passed the
// input register. Throughput: one character per cycle while the buffer is not full;
// the decode update is a combinational shift, OR and 32-bit add between the input
// register and the result buffer. Stall on the response side backs up through the
// two-entry result buffer. Reset (synchronous, active high) clears the decode state,
// empties the buffer and sets max_points to 65535.
`timescale 1ns / 1ps

module polyline_delta_decoder_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_wr_en,
   input  logic [15:0]        csr_wr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_char_byte,
   input  logic               req_end_of_string,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_lat_units,
   output logic signed [31:0] rsp_lon_units,
   output logic               rsp_point_valid,
   output logic [1:0]         rsp_status,
   output logic [15:0]        rsp_points_so_far
);
   import pdd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_char_ff;
   logic       in_eos_ff;
   logic       fifo_full;
   logic       fire;
   logic       res_valid;
   rsp_type    res;
   rsp_type    out_data;

   // Input stage handshake
   always_comb begin
      fire        = in_valid_ff && !fifo_full;
      req_stall   = in_valid_ff && fifo_full;
      in_valid_in = (req_valid && !req_stall) || (in_valid_ff && !fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Input payload capture
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_char_ff <= req_char_byte;
         in_eos_ff  <= req_end_of_string;
      end
   end

   pdd_core u_core (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .fire          (fire),
      .char_byte     (in_char_ff),
      .end_of_string (in_eos_ff),
      .res_valid     (res_valid),
      .res           (res)
   );

   pdd_out_fifo u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .full      (fifo_full),
      .pop_valid (rsp_valid),
      .pop_stall (rsp_stall),
      .pop_data  (out_data)
   );

   // Result beat fields
   assign rsp_lat_units     = out_data.lat_units;
   assign rsp_lon_units     = out_data.lon_units;
   assign rsp_point_valid   = out_data.point_valid;
   assign rsp_status        = out_data.status;
   assign rsp_points_so_far = out_data.points_so_far;

endmodule

// File: src/pdd_core.sv
// Decode state and per-character update logic of the polyline decoder.
`timescale 1ns / 1ps

module pdd_core (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_wr_en,
   input  logic [15:0]     csr_wr_data,
   input  logic            fire,
   input  logic [7:0]      char_byte,
   input  logic            end_of_string,
   output logic            res_valid,
   output pdd_pkg::rsp_type res
);
   import pdd_pkg::*;

   logic [15:0] max_points_ff;
   logic [31:0] accum_ff,  accum_in;
   logic [2:0]  count_ff,  count_in;
   logic        on_lon_ff, on_lon_in;
   logic [31:0] lat_ff,    lat_in;
   logic [31:0] lon_ff,    lon_in;
   logic [15:0] points_ff, points_in;
   mode_type    mode_ff,   mode_in;

   logic [7:0]  biased;
   logic [4:0]  chunk;
   logic        more;
   logic [4:0]  shamt;
   logic [31:0] accum_new;
   logic [31:0] delta;
   logic [31:0] lat_sum;
   logic [31:0] lon_sum;
   logic [15:0] points_inc;

   // Chunk extraction and zigzag decode
   always_comb begin
      biased     = char_byte - CHAR_BIAS;
      chunk      = biased[4:0];
      more       = (char_byte >= CONT_LOW) && (char_byte <= CONT_HIGH);
      shamt      = {count_ff, 2'b00} + {2'b00, count_ff};
      accum_new  = accum_ff | ({27'd0, chunk} << shamt);
      delta      = accum_new[0] ? ~(accum_new >> 1) : (accum_new >> 1);
      lat_sum    = lat_ff + delta;
      lon_sum    = lon_ff + delta;
      points_inc = points_ff + 16'd1;
   end

   // Next state and result
   always_comb begin
      accum_in  = accum_ff;
      count_in  = count_ff;
      on_lon_in = on_lon_ff;
      lat_in    = lat_ff;
      lon_in    = lon_ff;
      points_in = points_ff;
      mode_in   = mode_ff;
      res_valid = 1'b0;
      res.lat_units     = '0;
      res.lon_units     = '0;
      res.point_valid   = 1'b0;
      res.status        = STAT_BUSY;
      res.points_so_far = points_ff;

      if (mode_ff != MODE_DECODING) begin
         // stopped or voided: only the string end matters
         if (end_of_string && (mode_ff == MODE_LIMIT)) begin
            res_valid     = 1'b1;
            res.lat_units = lat_ff;
            res.lon_units = lon_ff;
            res.status    = STAT_DONE;
         end
      end else if (count_ff >= MAX_CHUNKS) begin
         // eighth chunk voids the string
         res_valid  = 1'b1;
         res.status = STAT_OVERLONG;
         mode_in    = MODE_VOID;
      end else if (more) begin
         accum_in = accum_new;
         count_in = count_ff + 3'd1;
         if (end_of_string) begin
            res_valid  = 1'b1;
            res.status = STAT_TRUNC;
         end
      end else begin
         accum_in = '0;
         count_in = '0;
         if (!on_lon_ff) begin
            lat_in    = lat_sum;
            on_lon_in = 1'b1;
            if (end_of_string) begin
               res_valid  = 1'b1;
               res.status = STAT_TRUNC;
            end
         end else begin
            lon_in            = lon_sum;
            on_lon_in         = 1'b0;
            points_in         = points_inc;
            res_valid         = 1'b1;
            res.lat_units     = lat_ff;
            res.lon_units     = lon_sum;
            res.point_valid   = 1'b1;
            res.status        = end_of_string ? STAT_DONE : STAT_BUSY;
            res.points_so_far = points_inc;
            if (points_inc >= max_points_ff) begin
               mode_in = MODE_LIMIT;
            end
         end
      end

      // string end clears per-string state
      if (end_of_string) begin
         accum_in  = '0;
         count_in  = '0;
         on_lon_in = 1'b0;
         lat_in    = '0;
         lon_in    = '0;
         points_in = '0;
         mode_in   = MODE_DECODING;
      end

      if (!fire) begin
         res_valid = 1'b0;
      end
   end

   // Configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         max_points_ff <= MAX_PTS_RST;
      end else if (csr_wr_en) begin
         max_points_ff <= csr_wr_data;
      end
   end

   // Decode state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         accum_ff  <= '0;
         count_ff  <= '0;
         on_lon_ff <= 1'b0;
         lat_ff    <= '0;
         lon_ff    <= '0;
         points_ff <= '0;
         mode_ff   <= MODE_DECODING;
      end else if (fire) begin
         accum_ff  <= accum_in;
         count_ff  <= count_in;
         on_lon_ff <= on_lon_in;
         lat_ff    <= lat_in;
         lon_ff    <= lon_in;
         points_ff <= points_in;
         mode_ff   <= mode_in;
      end
   end

endmodule

// File: src/pdd_out_fifo.sv
// Two-entry result buffer between the decoder and the response channel.
`timescale 1ns / 1ps

module pdd_out_fifo (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  pdd_pkg::rsp_type push_data,
   output logic            full,
   output logic            pop_valid,
   input  logic            pop_stall,
   output pdd_pkg::rsp_type pop_data
);
   import pdd_pkg::*;

   rsp_type     mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff,  count_in;
   logic        pop;

   // Pointer and occupancy update
   always_comb begin
      pop       = (count_ff != 2'd0) && !pop_stall;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
      full      = (count_ff == 2'd2);
      pop_valid = (count_ff != 2'd0);
      pop_data  = mem_ff[rd_ptr_ff];
   end

   // Storage, payload only
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule
